FILE: hdl/cks_pkg.sv
// ----------------------------------------------------------------------------
// cks_pkg: shared types and constants for the card key slot table
// Command codes, sequencer states and the default table size.
// ----------------------------------------------------------------------------
package cks_pkg;

   // Default number of slots in the table
   localparam int SLOTS_DEF = 32;

   // Width of the card and sensor identifiers
   localparam int ID_W = 32;

   // Width of the slot number fields on the ports
   localparam int SLOT_W = 5;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_ASSIGN  = 2'd1,
      CMD_NEAREST = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SEARCH,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/card_key_slot_table.sv
// ----------------------------------------------------------------------------
// card_key_slot_table: slot table binding cards and sensors to key slots
// Lookup, assign, nearest-free search and clear over a table of SLOTS slots.
// ----------------------------------------------------------------------------
// One request at a time. Lookup and assign pass through ST_SCAN and ST_DRAIN
// to ST_DONE, nearest-free adds ST_SEARCH and clear goes straight to ST_DONE:
// the table sits in a memory with one read port that is scanned one entry per
// cycle through a single compare unit, and the free-slot search then steps the
// lower and upper ring pointers one slot per cycle. Reset and clear act at
// once through per-slot valid bits, so there is no clearing pass. A finished
// response may wait in the output register while the next request is taken.
module card_key_slot_table
   import cks_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_card_id,
   input  logic [ID_W-1:0]   req_sensor_id,
   input  logic [SLOT_W-1:0] req_slot,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [SLOT_W-1:0] rsp_match_slot,
   output logic              rsp_lower_valid,
   output logic [SLOT_W-1:0] rsp_lower_slot,
   output logic              rsp_upper_valid,
   output logic [SLOT_W-1:0] rsp_upper_slot,
   // configuration
   input  logic              csr_write,
   input  logic              csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SEXT_W = IDX_W + SLOT_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   // Table memory and per-slot status bits
   logic [ID_W-1:0]  mem_card   [SLOTS];
   logic [ID_W-1:0]  mem_sensor [SLOTS];
   logic [ID_W-1:0]  rd_card_ff, rd_sensor_ff;
   logic             mem_we;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] occ_ff, occ_in;

   logic             match_sensor_ff;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [ID_W-1:0]  card_ff, card_in;
   logic [ID_W-1:0]  sensor_ff, sensor_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] li_ff, li_in;
   logic [IDX_W-1:0] ui_ff, ui_in;
   logic [IDX_W-1:0] off_ff, off_in;
   logic             lo_ok_ff, lo_ok_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic             up_ok_ff, up_ok_in;
   logic [IDX_W-1:0] up_ff, up_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_match_ff, rsp_match_in;
   logic              rsp_lo_vld_ff, rsp_lo_vld_in;
   logic [SLOT_W-1:0] rsp_lo_ff, rsp_lo_in;
   logic              rsp_up_vld_ff, rsp_up_vld_in;
   logic [SLOT_W-1:0] rsp_up_ff, rsp_up_in;

   logic [SEXT_W-1:0] slot_ext;
   logic [IDX_W-1:0]  bind_idx;
   logic              bind_ok;
   logic [ID_W-1:0]   cmp_card;
   logic [ID_W-1:0]   cmp_sensor;
   logic              match_now;
   logic              hit_now;
   logic [IDX_W-1:0]  base_now;
   logic              rsp_free;

   // Bind target for assign
   assign slot_ext = SEXT_W'(slot_ff);
   assign bind_idx = slot_ext[IDX_W-1:0];
   assign bind_ok  = (32'(slot_ff) < 32'(SLOTS));

   // A slot never bound, or freed, reads as card 0 and sensor 0
   assign cmp_card   = valid_ff[cmp_idx_ff] ? rd_card_ff : '0;
   assign cmp_sensor = valid_ff[cmp_idx_ff] ? rd_sensor_ff : '0;

   // Shared compare unit on the entry read last cycle
   assign match_now = cmp_vld_ff && (cmp_card == card_ff) &&
                      (!match_sensor_ff || (cmp_sensor == sensor_ff));
   assign hit_now   = hit_ff || match_now;
   assign base_now  = (!hit_ff && match_now) ? cmp_idx_ff : base_ff;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      card_in       = card_ff;
      sensor_in     = sensor_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_now;
      base_in       = base_now;
      li_in         = li_ff;
      ui_in         = ui_ff;
      off_in        = off_ff;
      lo_ok_in      = lo_ok_ff;
      lo_in         = lo_ff;
      up_ok_in      = up_ok_ff;
      up_in         = up_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_lo_vld_in = rsp_lo_vld_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_up_vld_in = rsp_up_vld_ff;
      rsp_up_in     = rsp_up_ff;

      // assign frees every matching slot as the scan passes it
      if (match_now && (cmd_ff == CMD_ASSIGN)) begin
         valid_in[cmp_idx_ff] = 1'b0;
         occ_in[cmp_idx_ff]   = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               card_in   = req_card_id;
               sensor_in = req_sensor_id;
               slot_in   = req_slot;
               idx_in    = '0;
               hit_in    = 1'b0;
               base_in   = '0;
               lo_ok_in  = 1'b0;
               lo_in     = '0;
               up_ok_in  = 1'b0;
               up_in     = '0;
               if (cmd_type'(req_cmd) == CMD_CLEAR) begin
                  valid_in = '0;
                  occ_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == LAST) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last compare lands here; bind goes after the frees
            if (cmd_ff == CMD_ASSIGN) begin
               if (bind_ok) begin
                  mem_we             = 1'b1;
                  valid_in[bind_idx] = 1'b1;
                  occ_in[bind_idx]   = (card_ff != '0);
               end
               state_in = ST_DONE;
            end else if (cmd_ff == CMD_NEAREST) begin
               li_in    = hit_now ? base_now : LAST;
               ui_in    = hit_now ? base_now : '0;
               off_in   = '0;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SEARCH: begin
            // walk both ring pointers one step per cycle
            if (!lo_ok_ff && !occ_ff[li_ff]) begin
               lo_ok_in = 1'b1;
               lo_in    = li_ff;
            end
            if (!up_ok_ff && !occ_ff[ui_ff]) begin
               up_ok_in = 1'b1;
               up_in    = ui_ff;
            end
            li_in = (li_ff == '0) ? LAST : li_ff - 1'b1;
            ui_in = (ui_ff == LAST) ? '0 : ui_ff + 1'b1;
            if (off_ff == LAST) begin
               state_in = ST_DONE;
            end else begin
               off_in = off_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_match_in  = '0;
               rsp_lo_vld_in = 1'b0;
               rsp_lo_in     = '0;
               rsp_up_vld_in = 1'b0;
               rsp_up_in     = '0;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     rsp_found_in = hit_ff;
                     rsp_match_in = SLOT_W'(base_ff);
                  end
                  CMD_ASSIGN: begin
                     rsp_found_in = bind_ok;
                     rsp_match_in = bind_ok ? slot_ff : '0;
                  end
                  CMD_NEAREST: begin
                     rsp_found_in  = hit_ff;
                     rsp_match_in  = SLOT_W'(base_ff);
                     rsp_lo_vld_in = lo_ok_ff;
                     rsp_lo_in     = SLOT_W'(lo_ff);
                     rsp_up_vld_in = up_ok_ff;
                     rsp_up_in     = SLOT_W'(up_ff);
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cmp_vld_ff      <= 1'b0;
         valid_ff        <= '0;
         occ_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         match_sensor_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            match_sensor_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      card_ff       <= card_in;
      sensor_ff     <= sensor_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      base_ff       <= base_in;
      li_ff         <= li_in;
      ui_ff         <= ui_in;
      off_ff        <= off_in;
      lo_ok_ff      <= lo_ok_in;
      lo_ff         <= lo_in;
      up_ok_ff      <= up_ok_in;
      up_ff         <= up_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_lo_vld_ff <= rsp_lo_vld_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_up_vld_ff <= rsp_up_vld_in;
      rsp_up_ff     <= rsp_up_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_card[bind_idx]   <= card_ff;
         mem_sensor[bind_idx] <= sensor_ff;
      end
      rd_card_ff   <= mem_card[idx_ff];
      rd_sensor_ff <= mem_sensor[idx_ff];
   end

   // Ports
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_slot  = rsp_match_ff;
   assign rsp_lower_valid = rsp_lo_vld_ff;
   assign rsp_lower_slot  = rsp_lo_ff;
   assign rsp_upper_valid = rsp_up_vld_ff;
   assign rsp_upper_slot  = rsp_up_ff;

   // Checks
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("compare active outside the table scan");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_cmd == CMD_CLEAR)
      |=> (valid_ff == '0 && occ_ff == '0))
      else $error("clear left slots in use");

   a_lower_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && cmd_ff == CMD_NEAREST && lo_ok_ff) |-> !occ_ff[lo_ff])
      else $error("lower slot reported free is in use");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished request did not reach the response register");

endmodule

FILE: test/card_key_slot_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_key_slot_table_test: self-checking bench for the card key slot table
// Drives lookup, assign, nearest-free and clear requests through the
// valid/stall request channel. A scoreboard keeps its own copy of the slot
// table and predicts each response. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module card_key_slot_table_test;
   import cks_pkg::*;

   // One response, packed in port order
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] match_slot;
      logic              lower_valid;
      logic [SLOT_W-1:0] lower_slot;
      logic              upper_valid;
      logic [SLOT_W-1:0] upper_slot;
   } slot_reply_type;

   // Scoreboard: shadow slot table, reply predictor and reply checker
   class slot_table_scoreboard;
      logic [ID_W-1:0] card_of[SLOTS_DEF];
      logic [ID_W-1:0] sensor_of[SLOTS_DEF];
      bit              sensor_check;
      slot_reply_type  pending_replies[$];
      int              errors;

      function new();
         foreach (card_of[k]) begin
            card_of[k]   = '0;
            sensor_of[k] = '0;
         end
         sensor_check = 1'b1;
         errors       = 0;
      endfunction

      function bit slot_hits(int k, logic [ID_W-1:0] card, logic [ID_W-1:0] sensor);
         return card_of[k] == card && (!sensor_check || sensor_of[k] == sensor);
      endfunction

      // Apply one accepted request to the table and queue its reply
      function void predict_reply(cmd_type cmd, logic [ID_W-1:0] card,
                                  logic [ID_W-1:0] sensor, logic [SLOT_W-1:0] slot);
         slot_reply_type r;
         int          base;
         int          k;
         int          li;
         int          ui;
         bit          hit;
         r    = '0;
         hit  = 1'b0;
         base = 0;
         // lowest matching slot
         for (k = SLOTS_DEF - 1; k >= 0; k--) begin
            if (slot_hits(k, card, sensor)) begin
               hit  = 1'b1;
               base = k;
            end
         end
         case (cmd)
            CMD_LOOKUP: begin
               r.found      = hit;
               r.match_slot = hit ? SLOT_W'(base) : '0;
            end
            CMD_ASSIGN: begin
               for (k = 0; k < SLOTS_DEF; k++) begin
                  if (slot_hits(k, card, sensor)) begin
                     card_of[k]   = '0;
                     sensor_of[k] = '0;
                  end
               end
               card_of[slot]   = card;
               sensor_of[slot] = sensor;
               r.found         = 1'b1;
               r.match_slot    = slot;
            end
            CMD_NEAREST: begin
               r.found      = hit;
               r.match_slot = hit ? SLOT_W'(base) : '0;
               // walk both ring pointers, from the match or from the ends
               for (k = 0; k < SLOTS_DEF; k++) begin
                  if (hit) begin
                     li = (base + SLOTS_DEF - k) % SLOTS_DEF;
                     ui = (base + k) % SLOTS_DEF;
                  end else begin
                     li = SLOTS_DEF - 1 - k;
                     ui = k;
                  end
                  if (!r.lower_valid && card_of[li] == '0) begin
                     r.lower_valid = 1'b1;
                     r.lower_slot  = SLOT_W'(li);
                  end
                  if (!r.upper_valid && card_of[ui] == '0) begin
                     r.upper_valid = 1'b1;
                     r.upper_slot  = SLOT_W'(ui);
                  end
               end
            end
            default: begin
               foreach (card_of[j]) begin
                  card_of[j]   = '0;
                  sensor_of[j] = '0;
               end
            end
         endcase
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare an accepted response with the oldest prediction
      function void check_reply(slot_reply_type got);
         slot_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("found", 32'(want.found), 32'(got.found));
         compare_field("match_slot", 32'(want.match_slot), 32'(got.match_slot));
         compare_field("lower_valid", 32'(want.lower_valid), 32'(got.lower_valid));
         compare_field("lower_slot", 32'(want.lower_slot), 32'(got.lower_slot));
         compare_field("upper_valid", 32'(want.upper_valid), 32'(got.upper_valid));
         compare_field("upper_slot", 32'(want.upper_slot), 32'(got.upper_slot));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [ID_W-1:0]   req_card_id;
   logic [ID_W-1:0]   req_sensor_id;
   logic [SLOT_W-1:0] req_slot;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_found;
   logic [SLOT_W-1:0] rsp_match_slot;
   logic              rsp_lower_valid;
   logic [SLOT_W-1:0] rsp_lower_slot;
   logic              rsp_upper_valid;
   logic [SLOT_W-1:0] rsp_upper_slot;
   logic              csr_write;
   logic              csr_wdata;

   slot_table_scoreboard table_model = new();
   logic [ID_W-1:0]      card_pool[8];
   logic [ID_W-1:0]      sensor_pool[4];
   int                   requests_sent = 0;
   bit                   calm = 1'b0;

   card_key_slot_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_card_id     (req_card_id),
      .req_sensor_id   (req_sensor_id),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_slot  (rsp_match_slot),
      .rsp_lower_valid (rsp_lower_valid),
      .rsp_lower_slot  (rsp_lower_slot),
      .rsp_upper_valid (rsp_upper_valid),
      .rsp_upper_slot  (rsp_upper_slot),
      .csr_write       (csr_write),
      .csr_wdata       (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Response side stalls in random bursts
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_stall <= 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            hold = $urandom_range(0, 30);
         end else begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(0, 18);
         end
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         table_model.check_reply({rsp_found, rsp_match_slot, rsp_lower_valid,
                                  rsp_lower_slot, rsp_upper_valid, rsp_upper_slot});
   end

   // Send one request, with an optional idle burst first
   task automatic issue_request(cmd_type cmd, logic [ID_W-1:0] card,
                                logic [ID_W-1:0] sensor, logic [SLOT_W-1:0] slot);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         repeat (gap) begin
            @(negedge clock);
            req_valid     <= 1'b0;
            req_cmd       <= 2'($urandom);
            req_card_id   <= $urandom;
            req_sensor_id <= $urandom;
            req_slot      <= SLOT_W'($urandom);
         end
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_card_id   <= card;
      req_sensor_id <= sensor;
      req_slot      <= slot;
      do @(posedge clock); while (req_stall !== 1'b0);
      table_model.predict_reply(cmd, card, sensor, slot);
      requests_sent++;
   endtask

   // Drop valid and wait until every response is back
   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (table_model.pending_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_match_sensor(logic value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      table_model.sensor_check = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Ids biased toward what the table holds, so matches are common
   task automatic pick_ids(output logic [ID_W-1:0] card, output logic [ID_W-1:0] sensor);
      int k;
      int r;
      k = $urandom_range(0, SLOTS_DEF - 1);
      r = $urandom_range(0, 99);
      if (r < 10)
         card = '0;
      else if (r < 25)
         card = $urandom;
      else if (r < 55)
         card = table_model.card_of[k];
      else
         card = card_pool[$urandom_range(0, 7)];
      r = $urandom_range(0, 99);
      if (r < 15)
         sensor = $urandom;
      else if (r < 55)
         sensor = table_model.sensor_of[k];
      else
         sensor = sensor_pool[$urandom_range(0, 3)];
   endtask

   // Stimulus
   initial begin
      int              phase;
      int              target;
      int              r;
      int              k;
      bit              whole;
      logic [ID_W-1:0] card;
      logic [ID_W-1:0] sensor;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_LOOKUP;
      req_card_id   = '0;
      req_sensor_id = '0;
      req_slot      = '0;
      csr_write     = 1'b0;
      csr_wdata     = 1'b0;
      card_pool[0]  = 32'hFFFF_FFFF;
      for (k = 1; k < 8; k++)
         card_pool[k] = $urandom_range(1, 32'hFFFF_FFFF);
      sensor_pool[0] = '0;
      sensor_pool[1] = 32'hFFFF_FFFF;
      sensor_pool[2] = $urandom;
      sensor_pool[3] = $urandom;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, sensor matching on (reset value)
      issue_request(CMD_LOOKUP, '0, '0, '0);                  // card 0 finds a free slot
      issue_request(CMD_NEAREST, 32'h1234, 32'h1, '0);        // no match: search from the ends
      issue_request(CMD_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      issue_request(CMD_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);  // moves the card off 31
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0);       // sensor differs
      issue_request(CMD_NEAREST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);   // lower wraps to 31
      issue_request(CMD_ASSIGN, '0, 32'h7, 5'd5);             // bind card 0
      issue_request(CMD_LOOKUP, '0, 32'h7, '0);
      issue_request(CMD_ASSIGN, '0, '0, 5'd1);                // frees every zero/zero slot
      issue_request(CMD_ASSIGN, 32'hA, 32'h1, 5'd1);
      issue_request(CMD_ASSIGN, 32'hB, 32'h1, 5'd2);
      issue_request(CMD_NEAREST, 32'hA, 32'h1, '0);
      issue_request(CMD_CLEAR, 32'hA, 32'h1, 5'd3);
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      wait_for_replies();

      // Directed, card id alone decides
      set_match_sensor(1'b0);
      issue_request(CMD_ASSIGN, 32'hC, 32'h1, 5'd10);
      issue_request(CMD_ASSIGN, 32'hC, 32'h2, 5'd20);         // frees slot 10
      issue_request(CMD_LOOKUP, 32'hC, 32'h9, '0);
      issue_request(CMD_NEAREST, 32'hC, 32'h3, '0);
      issue_request(CMD_LOOKUP, '0, 32'h5, '0);

      // Random phases, alternating the sensor match setting
      for (phase = 0; phase < 4; phase++) begin
         wait_for_replies();
         if (phase == 3)
            calm = 1'b1;
         set_match_sensor(phase % 2 == 0 ? 1'b1 : 1'b0);
         target = requests_sent + 345;
         while (requests_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
               // fill the table in slot order, often completely
               whole = $urandom_range(0, 1);
               for (k = 0; k < SLOTS_DEF; k++) begin
                  if (whole || $urandom_range(0, 7) != 0)
                     issue_request(CMD_ASSIGN, $urandom_range(1, 32'hFFFF_FFFF),
                                   $urandom, SLOT_W'(k));
               end
               repeat ($urandom_range(1, 3)) begin
                  pick_ids(card, sensor);
                  issue_request(CMD_NEAREST, card, sensor, SLOT_W'($urandom));
               end
            end else begin
               pick_ids(card, sensor);
               r = $urandom_range(0, 99);
               if (r < 35)
                  issue_request(CMD_ASSIGN, card, sensor, SLOT_W'($urandom));
               else if (r < 65)
                  issue_request(CMD_LOOKUP, card, sensor, SLOT_W'($urandom));
               else if (r < 97)
                  issue_request(CMD_NEAREST, card, sensor, SLOT_W'($urandom));
               else
                  issue_request(CMD_CLEAR, card, sensor, SLOT_W'($urandom));
            end
         end
      end

      // Drain, then allow time for any stray response
      wait_for_replies();
      repeat (80) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending_replies.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
